@@ design/sfef_pkg.sv @@
package sfef_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int SIG_BYTES  = 16;

  localparam int SIG_W  = 128;
  localparam int LEN_W  = 5;
  localparam int HELD_W = 5;
  localparam int SLOT_W = $clog2(HIST_DEPTH);
  localparam int CNT_W  = $clog2(HIST_DEPTH + 1);

  typedef struct packed {
    logic             op;
    logic [SIG_W-1:0] sig;
    logic [SIG_W-1:0] mask;
  } item_t;

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == SLOT_W'(HIST_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

endpackage

@@ design/sfef_ram.sv @@
module sfef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sfef_seq.sv @@
module sfef_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sfef_pkg::item_t                   item_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_dup_found,
  output logic [sfef_pkg::HELD_W-1:0]       out_held,
  output logic                              ram_we,
  output logic [sfef_pkg::SLOT_W-1:0]       ram_waddr,
  output logic [sfef_pkg::SIG_W-1:0]        ram_wdata,
  output logic                              ram_re,
  output logic [sfef_pkg::SLOT_W-1:0]       ram_raddr,
  input  logic [sfef_pkg::SIG_W-1:0]        ram_rdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [sfef_pkg::SLOT_W-1:0]     oldest_r, oldest_nxt;
  logic [sfef_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [sfef_pkg::CNT_W-1:0]      k_r, k_nxt;
  logic [sfef_pkg::SLOT_W-1:0]     rd_slot_r, rd_slot_nxt;
  logic [sfef_pkg::SIG_W-1:0]      sig_r, sig_nxt;
  logic [sfef_pkg::SIG_W-1:0]      mask_r, mask_nxt;
  logic                            dup_r, dup_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_dup_r, out_dup_nxt;
  logic [sfef_pkg::HELD_W-1:0]     out_held_r, out_held_nxt;

  logic [sfef_pkg::CNT_W:0]        tail_sum;
  logic [sfef_pkg::SLOT_W-1:0]     tail_slot;
  logic [sfef_pkg::SLOT_W-1:0]     next_slot;
  logic [sfef_pkg::CNT_W-1:0]      k_inc;
  logic                            full;
  logic                            accept;

  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_dup_found = out_dup_r;
  assign out_held      = out_held_r;
  assign ram_wdata     = item_i.sig;

  always_comb begin
    tail_sum = (sfef_pkg::CNT_W+1)'(oldest_r) + (sfef_pkg::CNT_W+1)'(count_r);
    if (tail_sum >= (sfef_pkg::CNT_W+1)'(sfef_pkg::HIST_DEPTH)) begin
      tail_slot = sfef_pkg::SLOT_W'(tail_sum - (sfef_pkg::CNT_W+1)'(sfef_pkg::HIST_DEPTH));
    end else begin
      tail_slot = sfef_pkg::SLOT_W'(tail_sum);
    end
    full      = (count_r == sfef_pkg::CNT_W'(sfef_pkg::HIST_DEPTH));
    next_slot = sfef_pkg::slot_inc(rd_slot_r);
    k_inc     = k_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    rd_slot_nxt   = rd_slot_r;
    sig_nxt       = sig_r;
    mask_nxt      = mask_r;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dup_nxt   = out_dup_r;
    out_held_nxt  = out_held_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_slot;
    ram_re        = 1'b0;
    ram_raddr     = oldest_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sig_nxt  = item_i.sig;
          mask_nxt = item_i.mask;
          dup_nxt  = 1'b0;
          if (item_i.op == sfef_pkg::OP_MARK) begin
            ram_we = 1'b1;
            if (full) begin
              ram_waddr  = oldest_r;
              oldest_nxt = sfef_pkg::slot_inc(oldest_r);
            end else begin
              count_nxt = count_r + 1'b1;
            end
            state_nxt = ST_DONE;
          end else if (count_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = oldest_r;
            rd_slot_nxt = oldest_r;
            k_nxt       = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if ((ram_rdata & mask_r) == sig_r) begin
          dup_nxt    = 1'b1;
          oldest_nxt = rd_slot_r;
          count_nxt  = count_r - k_r;
          state_nxt  = ST_DONE;
        end else if (k_inc == count_r) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt       = k_inc;
          ram_re      = 1'b1;
          ram_raddr   = next_slot;
          rd_slot_nxt = next_slot;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = dup_r;
          out_held_nxt  = sfef_pkg::HELD_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    rd_slot_r  <= rd_slot_nxt;
    sig_r      <= sig_nxt;
    mask_r     <= mask_nxt;
    dup_r      <= dup_nxt;
    out_dup_r  <= out_dup_nxt;
    out_held_r <= out_held_nxt;
  end

endmodule

@@ design/sent_frame_echo_filter.sv @@
// Echo filter for frames this port sent. A mark item (op 0) appends the
// frame's first min(length, 16) bytes, zero padded, to a 16-entry history
// ring; when full, the oldest entry is overwritten. A check item (op 1)
// compares its leading bytes against each entry from the oldest on, one
// memory read per cycle; on the first hit it reports dup_found and drops all
// older entries. held gives the entry count after the item. A mark, and a
// check on an empty history, pass from the accept through ST_DONE into the
// output register. Otherwise a check reads one entry per cycle through the
// single read port of the history memory in ST_SCAN, from the oldest entry
// until a hit or the newest, then goes through ST_DONE. The next item can be
// accepted in the same cycle as the result turns valid. A finished result
// waits in an output register while the next item is accepted; an item that
// finishes while that register still holds an unaccepted result waits for it.
module sent_frame_echo_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [63:0]                   in_sig_low,
  input  logic [63:0]                   in_sig_high,
  input  logic [sfef_pkg::LEN_W-1:0]    in_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_dup_found,
  output logic [sfef_pkg::HELD_W-1:0]   out_held
);

  logic [sfef_pkg::LEN_W-1:0]   len_sat;
  logic [sfef_pkg::SIG_W-1:0]   mask;
  sfef_pkg::item_t              item;
  logic                         ram_we;
  logic [sfef_pkg::SLOT_W-1:0]  ram_waddr;
  logic [sfef_pkg::SIG_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [sfef_pkg::SLOT_W-1:0]  ram_raddr;
  logic [sfef_pkg::SIG_W-1:0]   ram_rdata;

  always_comb begin
    if (in_length > sfef_pkg::LEN_W'(sfef_pkg::SIG_BYTES)) begin
      len_sat = sfef_pkg::LEN_W'(sfef_pkg::SIG_BYTES);
    end else begin
      len_sat = in_length;
    end
    for (int i = 0; i < sfef_pkg::SIG_W / 8; i++) begin
      mask[i*8 +: 8] = (sfef_pkg::LEN_W'(i) < len_sat) ? 8'hFF : 8'h00;
    end
    item.op   = in_op;
    item.mask = mask;
    item.sig  = {in_sig_high, in_sig_low} & mask;
  end

  sfef_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .item_i        (item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dup_found (out_dup_found),
    .out_held      (out_held),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  sfef_ram #(
    .WIDTH (sfef_pkg::SIG_W),
    .DEPTH (sfef_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

typedef struct {
  bit       dup;
  bit [4:0] held;
} verdict_t;

class echo_tracker;
  bit [127:0]  entry_sig [sfef_pkg::HIST_DEPTH];
  int unsigned oldest;
  int unsigned live;
  verdict_t    pending_verdicts[$];
  int          errors;

  function void record_frame(bit op, bit [127:0] sig, bit [4:0] len);
    int unsigned n;
    int unsigned slot;
    bit [127:0]  mask;
    bit [127:0]  key;
    verdict_t    v;
    n = (len > sfef_pkg::SIG_BYTES) ? sfef_pkg::SIG_BYTES : len;
    mask = (n >= 16) ? '1 : ((128'd1 << (8 * n)) - 128'd1);
    key = sig & mask;
    v.dup = 1'b0;
    if (op == sfef_pkg::OP_MARK) begin
      if (live >= sfef_pkg::HIST_DEPTH) begin
        slot = oldest;
        oldest = (oldest + 1) % sfef_pkg::HIST_DEPTH;
      end else begin
        slot = (oldest + live) % sfef_pkg::HIST_DEPTH;
        live++;
      end
      entry_sig[slot] = key;
    end else begin
      for (int k = 0; k < live; k++) begin
        slot = (oldest + k) % sfef_pkg::HIST_DEPTH;
        if ((entry_sig[slot] & mask) == key) begin
          v.dup = 1'b1;
          oldest = slot;
          live -= k;
          break;
        end
      end
    end
    v.held = live[4:0];
    pending_verdicts = {pending_verdicts, v};
  endfunction

  function void check_verdict(bit dup, bit [4:0] held);
    verdict_t v;
    if (pending_verdicts.size() == 0) begin
      $error("unexpected result: dup_found %0d held %0d", dup, held);
      errors++;
      return;
    end
    v = pending_verdicts.pop_front();
    if (dup !== v.dup) begin
      $error("dup_found: expected %0d, actual %0d", v.dup, dup);
      errors++;
    end
    if (held !== v.held) begin
      $error("held: expected %0d, actual %0d", v.held, held);
      errors++;
    end
  endfunction
endclass

module tb;

  typedef struct {
    bit [127:0] sig;
    bit [4:0]   len;
  } frame_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_op;
  logic [63:0]                 in_sig_low;
  logic [63:0]                 in_sig_high;
  logic [sfef_pkg::LEN_W-1:0]  in_length;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_dup_found;
  logic [sfef_pkg::HELD_W-1:0] out_held;

  echo_tracker tracker;
  frame_t      sent_log[$];
  bit [127:0]  sig_pool[4];
  bit          calm;
  bit          long_hold_due;
  int          items_sent;

  sent_frame_echo_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_sig_low   (in_sig_low),
    .in_sig_high  (in_sig_high),
    .in_length    (in_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_dup_found(out_dup_found),
    .out_held     (out_held)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [127:0] rand_sig();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic bit [4:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 5'd16;
    if (r < 70) return 5'($urandom_range(0, 3));
    if (r < 85) return 5'($urandom_range(4, 15));
    return 5'($urandom_range(17, 31));
  endfunction

  task automatic send_item(bit op, bit [127:0] sig, bit [4:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_sig_low  <= sig[63:0];
    in_sig_high <= sig[127:64];
    in_length   <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.record_frame(op, sig, len);
    items_sent++;
  endtask

  task automatic mark_frame(bit [127:0] sig, bit [4:0] len);
    frame_t f;
    f.sig = sig;
    f.len = len;
    sent_log = {sent_log, f};
    if (sent_log.size() > 40) void'(sent_log.pop_front());
    send_item(sfef_pkg::OP_MARK, sig, len);
  endtask

  task automatic check_echo();
    frame_t     f;
    bit [127:0] sig;
    bit [4:0]   len;
    int         span;
    int         n;
    int         r;
    r = $urandom_range(0, 99);
    if (sent_log.size() == 0 || r < 15) begin
      send_item(sfef_pkg::OP_CHECK, rand_sig(), rand_len());
      return;
    end
    span = (sent_log.size() < 20) ? sent_log.size() : 20;
    f = sent_log[sent_log.size() - 1 - $urandom_range(0, span - 1)];
    sig = f.sig;
    len = ($urandom_range(0, 9) < 7) ? f.len : 5'($urandom_range(0, f.len));
    n = (len > sfef_pkg::SIG_BYTES) ? sfef_pkg::SIG_BYTES : len;
    // corrupted echo: flip one byte inside the compared span
    if (r < 30 && n > 0)
      sig ^= 128'($urandom_range(1, 255)) << (8 * $urandom_range(0, n - 1));
    send_item(sfef_pkg::OP_CHECK, sig, len);
  endtask

  initial begin
    out_ready <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        int n;
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_verdict(out_dup_found, out_held);
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    bit [127:0] s_a;
    bit [127:0] s_b;
    bit [127:0] s_c;
    bit         hold_done;
    int         waited;
    tracker = new();
    calm = 1'b0;
    long_hold_due = 1'b0;
    hold_done = 1'b0;
    items_sent = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= sfef_pkg::OP_MARK;
    in_sig_low  <= '0;
    in_sig_high <= '0;
    in_length   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    s_a = rand_sig();
    s_b = rand_sig();
    s_c = rand_sig();
    send_item(sfef_pkg::OP_CHECK, rand_sig(), 5'd16);        // empty history
    send_item(sfef_pkg::OP_CHECK, '0, 5'd0);
    send_item(sfef_pkg::OP_MARK, '1, 5'd16);
    send_item(sfef_pkg::OP_MARK, '0, 5'd0);
    send_item(sfef_pkg::OP_MARK, s_a, 5'd31);                // saturated length
    send_item(sfef_pkg::OP_MARK, s_b, 5'd8);
    send_item(sfef_pkg::OP_MARK, s_c, 5'd9);
    send_item(sfef_pkg::OP_CHECK, rand_sig(), 5'd0);         // zero length hits oldest
    send_item(sfef_pkg::OP_CHECK, '1, 5'd16);
    send_item(sfef_pkg::OP_CHECK, s_a, 5'd17);               // drops two older entries
    send_item(sfef_pkg::OP_CHECK, rand_sig(), 5'd16);
    send_item(sfef_pkg::OP_CHECK, {~s_b[127:64], s_b[63:0]}, 5'd8);
    send_item(sfef_pkg::OP_CHECK, s_c, 5'd10);
    send_item(sfef_pkg::OP_CHECK, s_c, 5'd9);
    send_item(sfef_pkg::OP_MARK, {64'h0, s_c[63:0]}, 5'd1);
    send_item(sfef_pkg::OP_CHECK, '1, 5'd31);
    send_item(sfef_pkg::OP_CHECK, s_c, 5'd1);
    send_item(sfef_pkg::OP_MARK, '1, 5'd7);
    send_item(sfef_pkg::OP_CHECK, {64'h0, 64'h00ff_ffff_ffff_ffff}, 5'd7);
    send_item(sfef_pkg::OP_CHECK, '1, 5'd8);

    sig_pool[0] = rand_sig();
    sig_pool[1] = rand_sig();
    sig_pool[1][63:0] = sig_pool[0][63:0];
    sig_pool[2] = rand_sig();
    sig_pool[3] = {sig_pool[2][127:8], ~sig_pool[2][7:0]};

    while (items_sent < 1270) begin
      if (!hold_done && items_sent >= 350) begin
        hold_done = 1'b1;
        calm = 1'b1;
        long_hold_due = 1'b1;
      end
      if (calm && items_sent >= 520) calm = 1'b0;
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 4) == 0)
          mark_frame(sig_pool[$urandom_range(0, 3)], rand_len());
        else
          mark_frame(rand_sig(), rand_len());
      end
      repeat ($urandom_range(1, 6)) check_echo();
    end
    in_valid <= 1'b0;

    waited = 0;
    while (tracker.pending_verdicts.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (tracker.pending_verdicts.size() > 0) begin
      $error("%0d results never arrived", tracker.pending_verdicts.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
